FILE: sv/lplm_pkg.sv
// Shared types and constants for the link probe and lock monitor.
`timescale 1ns / 1ps

package lplm_pkg;

   // Controller modes, also the encoding of the fsm_state field
   typedef enum logic [2:0] {
      MODE_DISABLED = 3'd0,
      MODE_PROBING  = 3'd1,
      MODE_LOCKED   = 3'd2,
      MODE_LOST     = 3'd3,
      MODE_IDLE     = 3'd4
   } mode_type;

   // Link codes
   localparam logic [1:0] LINK_NONE    = 2'd0;
   localparam logic [1:0] LINK_CAN     = 2'd1;
   localparam logic [1:0] LINK_SERIAL  = 2'd2;
   localparam logic [1:0] LINK_NETWORK = 2'd3;

   // Event codes
   localparam logic [1:0] EVT_NONE         = 2'd0;
   localparam logic [1:0] EVT_NOT_DETECTED = 2'd1;
   localparam logic [1:0] EVT_LOCKED       = 2'd2;
   localparam logic [1:0] EVT_LOST         = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_LINKS_PRESENT  = 3'd0;
   localparam logic [2:0] CSR_COMM_ENABLED   = 3'd1;
   localparam logic [2:0] CSR_POLL_INTERVAL  = 3'd2;
   localparam logic [2:0] CSR_ATTEMPTS       = 3'd3;
   localparam logic [2:0] CSR_LOCK_NEEDED    = 3'd4;
   localparam logic [2:0] CSR_LOST_NEEDED    = 3'd5;
   localparam logic [2:0] CSR_REPLY_WINDOW   = 3'd6;
   localparam logic [2:0] CSR_COOLDOWN       = 3'd7;

   // Fixed timing constants
   localparam logic [15:0] DEFAULT_POLL_MS = 16'd5000;
   localparam logic [3:0]  COUNT_MAX       = 4'd15;
   localparam logic [15:0] CYCLES_MAX      = 16'hFFFF;

   // Number of order slots that can carry a real link
   localparam int LINK_SLOTS = 3;

   // Tick beat
   typedef struct packed {
      logic [31:0] now_ms;
      logic        request_accepted;
      logic        reply_ready;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [2:0]  fsm_state;
      logic [1:0]  target_link;
      logic        issue_request;
      logic        sample_reply;
      logic [1:0]  locked_link;
      logic [1:0]  event_code;
      logic [15:0] probe_cycles;
   } rsp_type;

endpackage

FILE: sv/link_probe_lock_monitor_core.sv
// Top level of the link probe and lock monitor: tick register, state update, result register.
`timescale 1ns / 1ps

//  channel | direction | beat                         | handshake
//  req     | in        | lplm_pkg::req_type tick      | req_valid / req_ready
//  rsp     | out       | lplm_pkg::rsp_type result    | rsp_valid / rsp_ready
//  csr     | in        | csr_index, csr_data write    | csr_valid / csr_ready
//
//  Each tick beat is registered in the input stage, then the state update logic
//  writes its result into the result register. A new tick is taken every cycle
//  while the result register is empty or rsp_ready is high; the single input stage
//  and result register hold beats while rsp_ready is low. Reset (synchronous)
//  leaves the block disabled with the configuration and controller registers at
//  their default values. csr writes are always accepted (csr_ready is tied high).

module link_probe_lock_monitor_core #(
   parameter int ORDER_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lplm_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lplm_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

   localparam int IDX_W = $clog2(ORDER_SLOTS + 1);

   // Configuration registers
   logic [2:0]  links_present_ff;
   logic        comm_enabled_ff;
   logic [15:0] poll_interval_ff;
   logic [3:0]  attempts_ff;
   logic [3:0]  lock_need_ff;
   logic [3:0]  lost_need_ff;
   logic [15:0] reply_window_ff;
   logic [31:0] cooldown_ff;

   // Controller state
   lplm_pkg::mode_type mode_ff, mode_in;
   logic [IDX_W-1:0]   order_idx_ff, order_idx_in;
   logic [1:0]         probe_link_ff, probe_link_in;
   logic [3:0]         attempt_cnt_ff, attempt_cnt_in;
   logic [3:0]         success_run_ff, success_run_in;
   logic               probe_wait_ff, probe_wait_in;
   logic [31:0]        probe_start_ff, probe_start_in;
   logic [1:0]         active_link_ff, active_link_in;
   logic               poll_wait_ff, poll_wait_in;
   logic [31:0]        poll_sent_ff, poll_sent_in;
   logic [31:0]        last_poll_ff, last_poll_in;
   logic [3:0]         fail_cnt_ff, fail_cnt_in;
   logic [31:0]        anchor_ff, anchor_in;
   logic [15:0]        cycle_cnt_ff, cycle_cnt_in;

   // Pipeline registers
   logic              in_valid_ff;
   lplm_pkg::req_type in_data_ff;
   logic              rsp_valid_ff;
   lplm_pkg::rsp_type rsp_data_ff, rsp_in;

   logic        advance;
   logic        csr_write;
   logic [7:0]  slot_mask;
   logic        found;
   logic        active_ok;
   logic [15:0] interval;
   logic [17:0] poll_window;
   logic [1:0]  target;
   logic        issue;
   logic        sample;
   logic [1:0]  event_code;

   // Handshakes
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Slot presence: slots from three up never hold a link
   assign slot_mask   = {5'b0, links_present_ff};
   assign active_ok   = (active_link_ff != lplm_pkg::LINK_NONE) &&
                        links_present_ff[active_link_ff - 2'd1];
   assign interval    = (poll_interval_ff != 16'd0) ? poll_interval_ff
                                                    : lplm_pkg::DEFAULT_POLL_MS;
   assign poll_window = {2'b0, reply_window_ff} + {1'b0, reply_window_ff, 1'b0};

   // State update for one tick, then csr side effects
   always_comb begin
      mode_in        = mode_ff;
      order_idx_in   = order_idx_ff;
      probe_link_in  = probe_link_ff;
      attempt_cnt_in = attempt_cnt_ff;
      success_run_in = success_run_ff;
      probe_wait_in  = probe_wait_ff;
      probe_start_in = probe_start_ff;
      active_link_in = active_link_ff;
      poll_wait_in   = poll_wait_ff;
      poll_sent_in   = poll_sent_ff;
      last_poll_in   = last_poll_ff;
      fail_cnt_in    = fail_cnt_ff;
      anchor_in      = anchor_ff;
      cycle_cnt_in   = cycle_cnt_ff;
      target         = lplm_pkg::LINK_NONE;
      issue          = 1'b0;
      sample         = 1'b0;
      event_code     = lplm_pkg::EVT_NONE;
      found          = 1'b0;

      if (advance) begin
         case (mode_ff)
            lplm_pkg::MODE_PROBING: begin
               // pick the next present link in priority order
               if (probe_link_ff == lplm_pkg::LINK_NONE) begin
                  for (int s = 0; s < ORDER_SLOTS; s++) begin
                     if (!found && (IDX_W'(s) >= order_idx_ff) && slot_mask[s]) begin
                        found          = 1'b1;
                        probe_link_in  = 2'(s + 1);
                        order_idx_in   = IDX_W'(s + 1);
                        attempt_cnt_in = 4'd0;
                     end
                  end
                  if (!found && (order_idx_ff < IDX_W'(ORDER_SLOTS))) begin
                     order_idx_in = IDX_W'(ORDER_SLOTS);
                  end
               end
               if (probe_link_in == lplm_pkg::LINK_NONE) begin
                  // nothing answered this round
                  if (cycle_cnt_ff == 16'd0) begin
                     event_code = lplm_pkg::EVT_NOT_DETECTED;
                  end
                  mode_in   = lplm_pkg::MODE_IDLE;
                  anchor_in = in_data_ff.now_ms;
                  if (cycle_cnt_ff != lplm_pkg::CYCLES_MAX) begin
                     cycle_cnt_in = cycle_cnt_ff + 16'd1;
                  end
               end else begin
                  target = probe_link_in;
                  if (!probe_wait_ff) begin
                     // send a probe request
                     issue = 1'b1;
                     if (in_data_ff.request_accepted) begin
                        probe_wait_in  = 1'b1;
                        probe_start_in = in_data_ff.now_ms;
                     end else begin
                        if (attempt_cnt_in != lplm_pkg::COUNT_MAX) begin
                           attempt_cnt_in = attempt_cnt_in + 4'd1;
                        end
                        if (attempt_cnt_in >= attempts_ff) begin
                           probe_link_in = lplm_pkg::LINK_NONE;
                        end
                     end
                  end else if (in_data_ff.reply_ready) begin
                     // good reply: extend the run, lock when long enough
                     if (success_run_ff != lplm_pkg::COUNT_MAX) begin
                        success_run_in = success_run_ff + 4'd1;
                     end
                     if (success_run_in >= lock_need_ff) begin
                        active_link_in = probe_link_in;
                        sample         = 1'b1;
                        mode_in        = lplm_pkg::MODE_LOCKED;
                        fail_cnt_in    = 4'd0;
                        poll_wait_in   = 1'b0;
                        probe_link_in  = lplm_pkg::LINK_NONE;
                        probe_wait_in  = 1'b0;
                        success_run_in = 4'd0;
                        order_idx_in   = '0;
                        anchor_in      = in_data_ff.now_ms;
                        event_code     = lplm_pkg::EVT_LOCKED;
                     end else begin
                        probe_wait_in = 1'b0;
                     end
                  end else if ((in_data_ff.now_ms - probe_start_ff) >
                               {16'd0, reply_window_ff}) begin
                     // reply window expired
                     probe_wait_in  = 1'b0;
                     success_run_in = 4'd0;
                     if (attempt_cnt_in != lplm_pkg::COUNT_MAX) begin
                        attempt_cnt_in = attempt_cnt_in + 4'd1;
                     end
                     if (attempt_cnt_in >= attempts_ff) begin
                        probe_link_in = lplm_pkg::LINK_NONE;
                     end
                  end
               end
            end

            lplm_pkg::MODE_LOCKED: begin
               if (!active_ok) begin
                  mode_in    = lplm_pkg::MODE_LOST;
                  anchor_in  = in_data_ff.now_ms;
                  event_code = lplm_pkg::EVT_LOST;
               end else begin
                  target = active_link_ff;
                  // periodic poll
                  if (!poll_wait_ff &&
                      ((in_data_ff.now_ms - last_poll_ff) >= {16'd0, interval})) begin
                     issue = 1'b1;
                     if (in_data_ff.request_accepted) begin
                        poll_wait_in = 1'b1;
                        poll_sent_in = in_data_ff.now_ms;
                     end else if (fail_cnt_in != lplm_pkg::COUNT_MAX) begin
                        fail_cnt_in = fail_cnt_in + 4'd1;
                     end
                     last_poll_in = in_data_ff.now_ms;
                  end
                  // poll reply or poll timeout
                  if (poll_wait_in) begin
                     if (in_data_ff.reply_ready) begin
                        sample       = 1'b1;
                        poll_wait_in = 1'b0;
                        fail_cnt_in  = 4'd0;
                     end else if ((in_data_ff.now_ms - poll_sent_in) >
                                  {14'd0, poll_window}) begin
                        poll_wait_in = 1'b0;
                        if (fail_cnt_in != lplm_pkg::COUNT_MAX) begin
                           fail_cnt_in = fail_cnt_in + 4'd1;
                        end
                     end
                  end
                  if (fail_cnt_in >= lost_need_ff) begin
                     mode_in    = lplm_pkg::MODE_LOST;
                     anchor_in  = in_data_ff.now_ms;
                     event_code = lplm_pkg::EVT_LOST;
                  end
               end
            end

            lplm_pkg::MODE_LOST: begin
               if ((in_data_ff.now_ms - anchor_ff) >= cooldown_ff) begin
                  mode_in        = lplm_pkg::MODE_PROBING;
                  order_idx_in   = '0;
                  probe_link_in  = lplm_pkg::LINK_NONE;
                  success_run_in = 4'd0;
                  attempt_cnt_in = 4'd0;
                  active_link_in = lplm_pkg::LINK_NONE;
               end
            end

            lplm_pkg::MODE_IDLE: begin
               if ((in_data_ff.now_ms - anchor_ff) >= cooldown_ff) begin
                  anchor_in      = in_data_ff.now_ms;
                  mode_in        = lplm_pkg::MODE_PROBING;
                  order_idx_in   = '0;
                  probe_link_in  = lplm_pkg::LINK_NONE;
                  success_run_in = 4'd0;
                  attempt_cnt_in = 4'd0;
               end
            end

            default: begin
            end
         endcase
      end

      // enable / disable writes act on the controller directly
      if (csr_write && (csr_index == lplm_pkg::CSR_COMM_ENABLED)) begin
         if (!csr_data[0]) begin
            mode_in        = lplm_pkg::MODE_DISABLED;
            probe_link_in  = lplm_pkg::LINK_NONE;
            active_link_in = lplm_pkg::LINK_NONE;
            probe_wait_in  = 1'b0;
            poll_wait_in   = 1'b0;
         end else if (mode_in == lplm_pkg::MODE_DISABLED) begin
            mode_in        = lplm_pkg::MODE_PROBING;
            order_idx_in   = '0;
            probe_link_in  = lplm_pkg::LINK_NONE;
            success_run_in = 4'd0;
            attempt_cnt_in = 4'd0;
            probe_wait_in  = 1'b0;
         end
      end

      rsp_in.fsm_state     = mode_in;
      rsp_in.target_link   = target;
      rsp_in.issue_request = issue;
      rsp_in.sample_reply  = sample;
      rsp_in.locked_link   = active_link_in;
      rsp_in.event_code    = event_code;
      rsp_in.probe_cycles  = cycle_cnt_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         links_present_ff <= 3'd0;
         comm_enabled_ff  <= 1'b0;
         poll_interval_ff <= 16'd5000;
         attempts_ff      <= 4'd3;
         lock_need_ff     <= 4'd2;
         lost_need_ff     <= 4'd3;
         reply_window_ff  <= 16'd1000;
         cooldown_ff      <= 32'd30000;
      end else if (csr_write) begin
         case (csr_index)
            lplm_pkg::CSR_LINKS_PRESENT: links_present_ff <= csr_data[2:0];
            lplm_pkg::CSR_COMM_ENABLED:  comm_enabled_ff  <= csr_data[0];
            lplm_pkg::CSR_POLL_INTERVAL: poll_interval_ff <= csr_data[15:0];
            lplm_pkg::CSR_ATTEMPTS:      attempts_ff      <= csr_data[3:0];
            lplm_pkg::CSR_LOCK_NEEDED:   lock_need_ff     <= csr_data[3:0];
            lplm_pkg::CSR_LOST_NEEDED:   lost_need_ff     <= csr_data[3:0];
            lplm_pkg::CSR_REPLY_WINDOW:  reply_window_ff  <= csr_data[15:0];
            lplm_pkg::CSR_COOLDOWN:      cooldown_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= lplm_pkg::MODE_DISABLED;
         order_idx_ff   <= '0;
         probe_link_ff  <= lplm_pkg::LINK_NONE;
         attempt_cnt_ff <= 4'd0;
         success_run_ff <= 4'd0;
         probe_wait_ff  <= 1'b0;
         probe_start_ff <= 32'd0;
         active_link_ff <= lplm_pkg::LINK_NONE;
         poll_wait_ff   <= 1'b0;
         poll_sent_ff   <= 32'd0;
         last_poll_ff   <= 32'd0;
         fail_cnt_ff    <= 4'd0;
         anchor_ff      <= 32'd0;
         cycle_cnt_ff   <= 16'd0;
      end else begin
         mode_ff        <= mode_in;
         order_idx_ff   <= order_idx_in;
         probe_link_ff  <= probe_link_in;
         attempt_cnt_ff <= attempt_cnt_in;
         success_run_ff <= success_run_in;
         probe_wait_ff  <= probe_wait_in;
         probe_start_ff <= probe_start_in;
         active_link_ff <= active_link_in;
         poll_wait_ff   <= poll_wait_in;
         poll_sent_ff   <= poll_sent_in;
         last_poll_ff   <= last_poll_in;
         fail_cnt_ff    <= fail_cnt_in;
         anchor_ff      <= anchor_in;
         cycle_cnt_ff   <= cycle_cnt_in;
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Checks
   a_stall_holds_tick: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held tick changed while stalled");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed tick produced no result");

   a_locked_has_link: assert property (@(posedge clock) disable iff (reset)
      mode_ff == lplm_pkg::MODE_LOCKED |->
         active_link_ff != lplm_pkg::LINK_NONE && probe_link_ff == lplm_pkg::LINK_NONE)
      else $error("locked without an active link");

   a_disabled_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff == lplm_pkg::MODE_DISABLED |->
         active_link_ff == lplm_pkg::LINK_NONE && !probe_wait_ff && !poll_wait_ff)
      else $error("disabled with live link state");

   a_enable_tracks_mode: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == lplm_pkg::MODE_DISABLED) == !comm_enabled_ff)
      else $error("enable bit and disabled mode disagree");

endmodule
